// File: hw/rtl/fnve_pkg.sv
// shared types, request codes and register indexes for the face value exchange block
`default_nettype none

package fnve_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX = 2'd3;

    localparam logic [15:0] EXPIRE_MS_RST = 16'd100;
    localparam logic [15:0] PROBE_MS_RST  = 16'd200;
    localparam logic [5:0]  VALUE_MAX_RST = 6'd63;
    localparam logic [7:0]  VALUE_PKT_LEN = 8'd2;

    localparam logic [2:0] REQ_RX      = 3'd0;
    localparam logic [2:0] REQ_TICK    = 3'd1;
    localparam logic [2:0] REQ_SET     = 3'd2;
    localparam logic [2:0] REQ_SET_ALL = 3'd3;
    localparam logic [2:0] REQ_QUERY   = 3'd4;

    localparam logic RESP_TX    = 1'b0;
    localparam logic RESP_QUERY = 1'b1;

    typedef struct packed {
        logic        enable;
        logic [15:0] expire_ms;
        logic [15:0] probe_ms;
        logic [5:0]  value_max;
    } t_cfg;

    // one face record as held in the state memory
    typedef struct packed {
        logic [5:0]  rcv;
        logic [5:0]  sent;
        logic [5:0]  seen;
        logic [31:0] expiry;
        logic [31:0] next_send;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        resp_kind;
        logic [2:0]  out_face;
        logic [7:0]  tx_first;
        logic [7:0]  tx_second;
        logic [5:0]  face_value;
        logic        value_changed;
        logic        face_expired;
        logic        all_alone;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    function automatic t_result tx_result(input logic [2:0] face, input logic [5:0] val,
                                          input logic is_last);
        t_result res;
        res               = '0;
        res.resp_kind     = RESP_TX;
        res.out_face      = face;
        res.tx_first      = {2'b00, val};
        res.tx_second     = ~{2'b00, val};
        res.last          = is_last;
        return res;
    endfunction

    function automatic t_result query_result(input logic [2:0] face, input logic [5:0] val,
                                             input logic changed, input logic expired,
                                             input logic alone);
        t_result res;
        res               = '0;
        res.resp_kind     = RESP_QUERY;
        res.out_face      = face;
        res.face_value    = val;
        res.value_changed = changed;
        res.face_expired  = expired;
        res.all_alone     = alone;
        res.last          = 1'b1;
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fnve_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module fnve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/fnve_cfg.sv
// configuration register file
`default_nettype none

module fnve_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [fnve_pkg::CFG_IDX_W-1:0]  i_idx,
    input  wire logic [fnve_pkg::CFG_DATA_W-1:0] i_wdata,
    output fnve_pkg::t_cfg                       o_cfg
);

    logic        r_enable;
    logic [15:0] r_expire_ms;
    logic [15:0] r_probe_ms;
    logic [5:0]  r_value_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_expire_ms <= fnve_pkg::EXPIRE_MS_RST;
            r_probe_ms  <= fnve_pkg::PROBE_MS_RST;
            r_value_max <= fnve_pkg::VALUE_MAX_RST;
        end else if (i_we) begin
            unique case (i_idx)
                fnve_pkg::CFG_ENABLE:    r_enable    <= i_wdata[0];
                fnve_pkg::CFG_EXPIRE_MS: r_expire_ms <= i_wdata[15:0];
                fnve_pkg::CFG_PROBE_MS:  r_probe_ms  <= i_wdata[15:0];
                fnve_pkg::CFG_VALUE_MAX: r_value_max <= i_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.enable    = r_enable;
    assign o_cfg.expire_ms = r_expire_ms;
    assign o_cfg.probe_ms  = r_probe_ms;
    assign o_cfg.value_max = r_value_max;

endmodule

`default_nettype wire

// File: hw/rtl/face_neighbor_value_exchange_top.sv
// per-face neighbor value exchange: request sequencer around one face state memory
//
//   channel   handshake              payload
//   request   start / busy           i_req_type i_face i_now_ms i_rx_* i_new_value
//   result    o_valid strobe         o_resp_kind o_out_face o_tx_* o_face_value ... o_last
//   config    i_cfg_we               i_cfg_idx i_cfg_wdata
//
// single-face requests (receive, set face) go through accept, read, modify/write, done
// tick, set-all and query walk all FACES entries, one memory read per cycle
// with the write-back of the previous entry in the same cycle
// tick results come out during the walk and the last one from the done state; a query answer after the walk
// synchronous active-low reset marks every entry empty, empty entries read as zero
// results are strobed for one cycle and cannot be held off
`default_nettype none

module face_neighbor_value_exchange_top #(
    parameter int FACES = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      i_req_type,
    input  wire logic [2:0]                      i_face,
    input  wire logic [31:0]                     i_now_ms,
    input  wire logic [7:0]                      i_rx_first,
    input  wire logic [7:0]                      i_rx_second,
    input  wire logic [7:0]                      i_rx_length,
    input  wire logic [7:0]                      i_new_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [fnve_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fnve_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                                 o_valid,
    output logic                                 o_resp_kind,
    output logic [2:0]                           o_out_face,
    output logic [7:0]                           o_tx_first,
    output logic [7:0]                           o_tx_second,
    output logic [5:0]                           o_face_value,
    output logic                                 o_value_changed,
    output logic                                 o_face_expired,
    output logic                                 o_all_alone,
    output logic                                 o_last
);

    localparam int AW = (FACES > 1) ? $clog2(FACES) : 1;
    localparam logic [3:0]    FACE_CNT  = 4'(FACES);
    localparam logic [AW-1:0] LAST_FACE = AW'(FACES - 1);

    fnve_pkg::t_cfg cfg;

    fnve_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // control
    fnve_pkg::t_state r_state;
    logic             r_issue;
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_rd_end;
    logic             r_p1_valid;
    logic [AW-1:0]    r_p1_face;
    logic             r_p1_last;
    logic             r_p1_hit;
    logic [FACES-1:0] r_vld;
    logic             r_pend_valid;
    logic             r_out_valid;

    // request payload
    logic [2:0]       r_req;
    logic [2:0]       r_face;
    logic [31:0]      r_now;
    logic             r_pkt_ok;
    logic [5:0]       r_rx_val;
    logic [5:0]       r_set_val;
    logic [AW-1:0]    r_pend_face;
    logic [5:0]       r_pend_val;
    logic             r_alone;
    logic [5:0]       r_q_value;
    logic             r_q_changed;
    logic             r_q_expired;
    fnve_pkg::t_result r_out;

    logic                         valid_face;
    logic                         has_work;
    logic                         all_scan;
    logic                         pkt_ok;
    logic [5:0]                   clamped;
    logic [fnve_pkg::ENTRY_W-1:0] ram_rdata;
    fnve_pkg::t_entry             ent;
    fnve_pkg::t_entry             n_entry;
    logic                         ram_we;
    logic                         now_exp;
    logic                         due;
    logic                         is_q_face;

    assign busy = (r_state != fnve_pkg::ST_IDLE);

    // request decode at accept
    always_comb begin
        valid_face = ({1'b0, i_face} < FACE_CNT);
        pkt_ok     = (i_rx_length == fnve_pkg::VALUE_PKT_LEN)
                   && (i_rx_first <= {2'b00, cfg.value_max})
                   && (i_rx_first == ~i_rx_second);
        clamped    = (i_new_value > {2'b00, cfg.value_max}) ? cfg.value_max : i_new_value[5:0];
        has_work   = 1'b0;
        all_scan   = 1'b0;
        unique case (i_req_type)
            fnve_pkg::REQ_RX:      has_work = cfg.enable && valid_face;
            fnve_pkg::REQ_TICK: begin
                has_work = cfg.enable;
                all_scan = 1'b1;
            end
            fnve_pkg::REQ_SET:     has_work = valid_face;
            fnve_pkg::REQ_SET_ALL: begin
                has_work = 1'b1;
                all_scan = 1'b1;
            end
            fnve_pkg::REQ_QUERY: begin
                has_work = 1'b1;
                all_scan = 1'b1;
            end
            default: ;
        endcase
    end

    fnve_ram #(
        .WIDTH (fnve_pkg::ENTRY_W),
        .DEPTH (FACES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_p1_face),
        .i_wdata (n_entry),
        .i_re    (r_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // modify stage on the entry read in the previous cycle
    always_comb begin
        ent       = r_p1_hit ? fnve_pkg::t_entry'(ram_rdata) : '0;
        now_exp   = (ent.expiry < r_now);
        due       = (ent.next_send <= r_now);
        is_q_face = (3'(r_p1_face) == r_face);
        n_entry   = ent;
        ram_we    = 1'b0;
        if (r_p1_valid) begin
            unique case (r_req)
                fnve_pkg::REQ_RX: begin
                    n_entry.expiry = r_now + 32'(cfg.expire_ms);
                    if (r_pkt_ok) begin
                        n_entry.rcv       = r_rx_val;
                        n_entry.next_send = '0;
                    end
                    ram_we = 1'b1;
                end
                fnve_pkg::REQ_TICK: begin
                    if (due) begin
                        n_entry.next_send = r_now + 32'(cfg.probe_ms);
                        ram_we            = 1'b1;
                    end
                end
                fnve_pkg::REQ_SET, fnve_pkg::REQ_SET_ALL: begin
                    n_entry.sent = r_set_val;
                    ram_we       = 1'b1;
                end
                fnve_pkg::REQ_QUERY: begin
                    if (is_q_face && (ent.rcv != ent.seen)) begin
                        n_entry.seen = ent.rcv;
                        ram_we       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fnve_pkg::ST_IDLE;
            r_issue      <= 1'b0;
            r_p1_valid   <= 1'b0;
            r_vld        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_p1_valid  <= r_issue;
            r_p1_face   <= r_rd_addr;
            r_p1_last   <= (r_rd_addr == r_rd_end);
            r_p1_hit    <= r_vld[r_rd_addr];
            if (ram_we) begin
                r_vld[r_p1_face] <= 1'b1;
            end
            if (r_issue) begin
                if (r_rd_addr == r_rd_end) begin
                    r_issue <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr + 1'b1;
                end
            end

            unique case (r_state)
                fnve_pkg::ST_IDLE: begin
                    if (start && has_work) begin
                        r_state      <= fnve_pkg::ST_SCAN;
                        r_issue      <= 1'b1;
                        r_rd_addr    <= all_scan ? '0 : i_face[AW-1:0];
                        r_rd_end     <= all_scan ? LAST_FACE : i_face[AW-1:0];
                        r_req        <= i_req_type;
                        r_face       <= i_face;
                        r_now        <= i_now_ms;
                        r_pkt_ok     <= pkt_ok;
                        r_rx_val     <= i_rx_first[5:0];
                        r_set_val    <= clamped;
                        r_pend_valid <= 1'b0;
                        r_alone      <= 1'b1;
                        r_q_value    <= '0;
                        r_q_changed  <= 1'b0;
                        r_q_expired  <= 1'b1;
                    end
                end
                fnve_pkg::ST_SCAN: begin
                    if (r_p1_valid) begin
                        if (r_req == fnve_pkg::REQ_QUERY) begin
                            r_alone <= r_alone & now_exp;
                            if (is_q_face) begin
                                r_q_value   <= ent.rcv;
                                r_q_changed <= (ent.rcv != ent.seen);
                                r_q_expired <= now_exp;
                            end
                        end
                        // hold one due face back so the final one can carry last
                        if ((r_req == fnve_pkg::REQ_TICK) && due) begin
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_out <= fnve_pkg::tx_result(3'(r_pend_face), r_pend_val, 1'b0);
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_face  <= r_p1_face;
                            r_pend_val   <= ent.sent;
                        end
                        if (r_p1_last) begin
                            r_state <= fnve_pkg::ST_DONE;
                        end
                    end
                end
                fnve_pkg::ST_DONE: begin
                    r_state <= fnve_pkg::ST_IDLE;
                    if ((r_req == fnve_pkg::REQ_TICK) && r_pend_valid) begin
                        r_out_valid <= 1'b1;
                        r_out <= fnve_pkg::tx_result(3'(r_pend_face), r_pend_val, 1'b1);
                    end
                    if (r_req == fnve_pkg::REQ_QUERY) begin
                        r_out_valid <= 1'b1;
                        r_out       <= fnve_pkg::query_result(r_face, r_q_value, r_q_changed,
                                                              r_q_expired, r_alone);
                    end
                end
                default: r_state <= fnve_pkg::ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_resp_kind     = r_out.resp_kind;
    assign o_out_face      = r_out.out_face;
    assign o_tx_first      = r_out.tx_first;
    assign o_tx_second     = r_out.tx_second;
    assign o_face_value    = r_out.face_value;
    assign o_value_changed = r_out.value_changed;
    assign o_face_expired  = r_out.face_expired;
    assign o_all_alone     = r_out.all_alone;
    assign o_last          = r_out.last;

    // write-back never lands on the entry being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_issue) |-> (r_p1_face != r_rd_addr))
        else $error("write-back collides with read of the same entry");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobed without a request in flight");

    a_query_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_resp_kind == fnve_pkg::RESP_QUERY)) |-> o_last)
        else $error("query answer not marked last");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == fnve_pkg::ST_SCAN))
        else $error("state memory written outside the walk");

endmodule

`default_nettype wire

// File: tb/tb_face_neighbor_value_exchange_top.sv
// testbench for face_neighbor_value_exchange_top: predicts every result and checks it in order

typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  face;
    logic [31:0] now_ms;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
    logic [7:0]  rx_length;
    logic [7:0]  new_value;
} t_exchange_req;

class face_exchange_scoreboard;
    localparam int NUM_FACES = 6;

    bit        enable;
    bit [15:0] expire_ms;
    bit [15:0] probe_ms;
    bit [5:0]  value_max;
    bit [5:0]  rcv_value  [NUM_FACES];
    bit [5:0]  sent_value [NUM_FACES];
    bit [5:0]  seen_value [NUM_FACES];
    bit [31:0] expiry     [NUM_FACES];
    bit [31:0] next_send  [NUM_FACES];
    fnve_pkg::t_result due_results[$];
    int mismatches;

    function new();
        enable     = 1'b1;
        expire_ms  = fnve_pkg::EXPIRE_MS_RST;
        probe_ms   = fnve_pkg::PROBE_MS_RST;
        value_max  = fnve_pkg::VALUE_MAX_RST;
        mismatches = 0;
    endfunction

    function void set_reg(logic [fnve_pkg::CFG_IDX_W-1:0] idx,
                          logic [fnve_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fnve_pkg::CFG_ENABLE:    enable    = data[0];
            fnve_pkg::CFG_EXPIRE_MS: expire_ms = data;
            fnve_pkg::CFG_PROBE_MS:  probe_ms  = data;
            fnve_pkg::CFG_VALUE_MAX: value_max = data[5:0];
            default: ;
        endcase
    endfunction

    // updates the face state for one accepted request and queues what it should produce
    function void apply_request(t_exchange_req r);
        fnve_pkg::t_result res;
        bit                have_res;
        bit                in_range;
        bit [5:0]          clamped;
        in_range = r.face < NUM_FACES;
        clamped  = (r.new_value > {2'b00, value_max}) ? value_max : r.new_value[5:0];
        have_res = 1'b0;
        res      = '0;
        case (r.req_type)
            fnve_pkg::REQ_RX: begin
                if (enable && in_range) begin
                    expiry[r.face] = r.now_ms + {16'd0, expire_ms};
                    if (r.rx_length == fnve_pkg::VALUE_PKT_LEN
                            && r.rx_first <= {2'b00, value_max}
                            && r.rx_first == ~r.rx_second) begin
                        rcv_value[r.face] = r.rx_first[5:0];
                        next_send[r.face] = '0;
                    end
                end
            end
            fnve_pkg::REQ_TICK: begin
                if (enable) begin
                    for (int f = 0; f < NUM_FACES; f++) begin
                        if (next_send[f] <= r.now_ms) begin
                            // hold the newest one back so the final one can carry last
                            if (have_res) due_results.push_back(res);
                            res           = '0;
                            res.resp_kind = fnve_pkg::RESP_TX;
                            res.out_face  = 3'(f);
                            res.tx_first  = {2'b00, sent_value[f]};
                            res.tx_second = ~{2'b00, sent_value[f]};
                            next_send[f]  = r.now_ms + {16'd0, probe_ms};
                            have_res      = 1'b1;
                        end
                    end
                    if (have_res) begin
                        res.last = 1'b1;
                        due_results.push_back(res);
                    end
                end
            end
            fnve_pkg::REQ_SET: begin
                if (in_range) sent_value[r.face] = clamped;
            end
            fnve_pkg::REQ_SET_ALL: begin
                for (int f = 0; f < NUM_FACES; f++) sent_value[f] = clamped;
            end
            fnve_pkg::REQ_QUERY: begin
                res.resp_kind    = fnve_pkg::RESP_QUERY;
                res.out_face     = r.face;
                res.face_expired = 1'b1;
                if (in_range) begin
                    res.face_value    = rcv_value[r.face];
                    res.value_changed = rcv_value[r.face] != seen_value[r.face];
                    seen_value[r.face] = rcv_value[r.face];
                    res.face_expired  = expiry[r.face] < r.now_ms;
                end
                res.all_alone = 1'b1;
                for (int f = 0; f < NUM_FACES; f++) begin
                    if (!(expiry[f] < r.now_ms)) res.all_alone = 1'b0;
                end
                res.last = 1'b1;
                due_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task report(string field, longint unsigned got, longint unsigned want);
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    task check_result(fnve_pkg::t_result got);
        fnve_pkg::t_result want;
        if (due_results.size() == 0) begin
            report("result with no request waiting, face", got.out_face, 0);
        end else begin
            want = due_results.pop_front();
            if (got.resp_kind != want.resp_kind)
                report("resp_kind", got.resp_kind, want.resp_kind);
            if (got.out_face != want.out_face)
                report("out_face", got.out_face, want.out_face);
            if (got.tx_first != want.tx_first)
                report("tx_first", got.tx_first, want.tx_first);
            if (got.tx_second != want.tx_second)
                report("tx_second", got.tx_second, want.tx_second);
            if (got.face_value != want.face_value)
                report("face_value", got.face_value, want.face_value);
            if (got.value_changed != want.value_changed)
                report("value_changed", got.value_changed, want.value_changed);
            if (got.face_expired != want.face_expired)
                report("face_expired", got.face_expired, want.face_expired);
            if (got.all_alone != want.all_alone)
                report("all_alone", got.all_alone, want.all_alone);
            if (got.last != want.last)
                report("last", got.last, want.last);
        end
    endtask
endclass

module tb_face_neighbor_value_exchange_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FACES    = 6;
    localparam int REG_COUNT    = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 8;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic [2:0]                      i_req_type  = '0;
    logic [2:0]                      i_face      = '0;
    logic [31:0]                     i_now_ms    = '0;
    logic [7:0]                      i_rx_first  = '0;
    logic [7:0]                      i_rx_second = '0;
    logic [7:0]                      i_rx_length = '0;
    logic [7:0]                      i_new_value = '0;
    logic                            i_cfg_we    = 1'b0;
    logic [fnve_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [fnve_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic        busy;
    logic        o_valid;
    logic        o_resp_kind;
    logic [2:0]  o_out_face;
    logic [7:0]  o_tx_first;
    logic [7:0]  o_tx_second;
    logic [5:0]  o_face_value;
    logic        o_value_changed;
    logic        o_face_expired;
    logic        o_all_alone;
    logic        o_last;

    fnve_pkg::t_result result_bus;
    face_exchange_scoreboard faces = new();
    bit [31:0] clock_ms;
    int idle_modes[4] = '{0, 79, 0, 24};

    face_neighbor_value_exchange_top #(
        .FACES(NUM_FACES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_face          (i_face),
        .i_now_ms        (i_now_ms),
        .i_rx_first      (i_rx_first),
        .i_rx_second     (i_rx_second),
        .i_rx_length     (i_rx_length),
        .i_new_value     (i_new_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_resp_kind     (o_resp_kind),
        .o_out_face      (o_out_face),
        .o_tx_first      (o_tx_first),
        .o_tx_second     (o_tx_second),
        .o_face_value    (o_face_value),
        .o_value_changed (o_value_changed),
        .o_face_expired  (o_face_expired),
        .o_all_alone     (o_all_alone),
        .o_last          (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign result_bus = {o_resp_kind, o_out_face, o_tx_first, o_tx_second, o_face_value,
                         o_value_changed, o_face_expired, o_all_alone, o_last};

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) faces.check_result(result_bus);
    end

    function automatic t_exchange_req make_req(logic [2:0] kind, logic [2:0] face,
                                               logic [31:0] now, logic [7:0] b0 = 8'd0,
                                               logic [7:0] b1 = 8'd0, logic [7:0] len = 8'd0,
                                               logic [7:0] nv = 8'd0);
        t_exchange_req r;
        r.req_type  = kind;
        r.face      = face;
        r.now_ms    = now;
        r.rx_first  = b0;
        r.rx_second = b1;
        r.rx_length = len;
        r.new_value = nv;
        return r;
    endfunction

    // start stays high on return so a following request can go out back to back
    task automatic issue(input t_exchange_req r);
        start       <= 1'b1;
        i_req_type  <= r.req_type;
        i_face      <= r.face;
        i_now_ms    <= r.now_ms;
        i_rx_first  <= r.rx_first;
        i_rx_second <= r.rx_second;
        i_rx_length <= r.rx_length;
        i_new_value <= r.new_value;
        do @(posedge i_clk); while (busy);
        faces.apply_request(r);
    endtask

    task automatic hold_requests(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // wait for every expected result, then let a request that makes none finish its walk
    task automatic drain();
        start <= 1'b0;
        while (faces.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input bit en, input bit [15:0] expire, input bit [15:0] probe,
                              input bit [5:0] vmax);
        logic [fnve_pkg::CFG_DATA_W-1:0] reg_data [REG_COUNT];
        reg_data[fnve_pkg::CFG_ENABLE]    = {15'($urandom), en};
        reg_data[fnve_pkg::CFG_EXPIRE_MS] = expire;
        reg_data[fnve_pkg::CFG_PROBE_MS]  = probe;
        reg_data[fnve_pkg::CFG_VALUE_MAX] = {10'($urandom), vmax};
        i_cfg_we <= 1'b1;
        for (int i = 0; i < REG_COUNT; i++) begin
            i_cfg_idx   <= fnve_pkg::CFG_IDX_W'(i);
            i_cfg_wdata <= reg_data[i];
            @(posedge i_clk);
            faces.set_reg(fnve_pkg::CFG_IDX_W'(i), reg_data[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int items);
        t_exchange_req r;
        int            counted;
        int            pick;
        int            gap;
        bit            ignored;
        counted = 0;
        while (counted < items) begin
            if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom_range(0, 70000);
            else clock_ms = clock_ms + $urandom_range(0, 120);
            r.now_ms    = ($urandom_range(0, 29) == 0) ? $urandom : clock_ms;
            r.face      = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_FACES, 7))
                                                      : 3'($urandom_range(0, NUM_FACES - 1));
            r.rx_first  = 8'($urandom);
            r.rx_second = 8'($urandom);
            r.rx_length = 8'($urandom);
            r.new_value = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r.req_type = fnve_pkg::REQ_RX;
                // mostly well-formed value packets, the rest broken in one way or another
                if ($urandom_range(0, 3) != 0) begin
                    r.rx_first  = 8'($urandom_range(0, faces.value_max));
                    r.rx_second = ~r.rx_first;
                    r.rx_length = fnve_pkg::VALUE_PKT_LEN;
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            r.rx_first  = 8'($urandom_range(0, faces.value_max));
                            r.rx_second = ~r.rx_first ^ (8'd1 << $urandom_range(0, 7));
                            r.rx_length = fnve_pkg::VALUE_PKT_LEN;
                        end
                        1: begin
                            r.rx_first  = 8'($urandom_range(0, faces.value_max));
                            r.rx_second = ~r.rx_first;
                        end
                        2: begin
                            r.rx_first  = 8'($urandom_range(faces.value_max + 1, 255));
                            r.rx_second = ~r.rx_first;
                            r.rx_length = fnve_pkg::VALUE_PKT_LEN;
                        end
                        default: ;
                    endcase
                end
            end else if (pick < 65) begin
                r.req_type = fnve_pkg::REQ_TICK;
            end else if (pick < 75) begin
                r.req_type = fnve_pkg::REQ_SET;
            end else if (pick < 79) begin
                r.req_type = fnve_pkg::REQ_SET_ALL;
            end else if (pick < 97) begin
                r.req_type = fnve_pkg::REQ_QUERY;
            end else begin
                r.req_type = 3'(fnve_pkg::REQ_QUERY + $urandom_range(1, 3));
            end
            ignored = (r.req_type > fnve_pkg::REQ_QUERY)
                   || (!faces.enable && (r.req_type == fnve_pkg::REQ_RX
                                         || r.req_type == fnve_pkg::REQ_TICK))
                   || ((r.req_type == fnve_pkg::REQ_RX || r.req_type == fnve_pkg::REQ_SET)
                       && r.face >= NUM_FACES);
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct) gap++;
            if (gap > 0) hold_requests(gap);
            else if ($urandom_range(0, 59) == 0) drain();
            issue(r);
            if (!ignored) counted++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: every face due at once, nothing received yet
        issue(make_req(fnve_pkg::REQ_QUERY, 3'd0, 32'd0));
        issue(make_req(fnve_pkg::REQ_TICK, 3'd0, 32'd0));
        issue(make_req(fnve_pkg::REQ_SET_ALL, 3'd0, 32'd10, 8'd0, 8'd0, 8'd0, 8'd17));
        issue(make_req(fnve_pkg::REQ_SET, 3'd2, 32'd10, 8'd0, 8'd0, 8'd0, 8'hFF));
        issue(make_req(fnve_pkg::REQ_SET, 3'd4, 32'd10, 8'd0, 8'd0, 8'd0, 8'd0));
        issue(make_req(fnve_pkg::REQ_SET, 3'd7, 32'd10, 8'd0, 8'd0, 8'd0, 8'd5));
        issue(make_req(fnve_pkg::REQ_RX, 3'd1, 32'd50, 8'h3F, 8'hC0, fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_RX, 3'd2, 32'd50, 8'h05, 8'h00, fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_RX, 3'd3, 32'd50, 8'h40, 8'hBF, fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_RX, 3'd4, 32'd50, 8'h09, 8'hF6, 8'd3));
        issue(make_req(fnve_pkg::REQ_RX, 3'd5, 32'd50, 8'h00, 8'hFF, fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_RX, 3'd6, 32'd50, 8'h07, 8'hF8, fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_RX, 3'd0, 32'd50, 8'hFF, 8'h00, 8'hFF));
        issue(make_req(fnve_pkg::REQ_TICK, 3'd0, 32'd60));
        issue(make_req(fnve_pkg::REQ_QUERY, 3'd1, 32'd60));
        issue(make_req(fnve_pkg::REQ_QUERY, 3'd1, 32'd60));
        issue(make_req(fnve_pkg::REQ_QUERY, 3'd7, 32'd200));
        for (int k = 1; k <= 3; k++) begin
            issue(make_req(3'(fnve_pkg::REQ_QUERY + k), 3'(k), 32'($urandom),
                           8'hFF, 8'hFF, 8'hFF, 8'hFF));
        end
        issue(make_req(fnve_pkg::REQ_TICK, 3'd0, 32'hFFFF_FFFF));
        // expiry wraps past zero and so reads as expired
        issue(make_req(fnve_pkg::REQ_RX, 3'd0, 32'hFFFF_FFF0, 8'h2A, 8'hD5,
                       fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_QUERY, 3'd0, 32'hFFFF_FFF5));

        // disabled: receive and tick do nothing, set and query still act
        drain();
        write_regs(1'b0, fnve_pkg::EXPIRE_MS_RST, fnve_pkg::PROBE_MS_RST,
                   fnve_pkg::VALUE_MAX_RST);
        issue(make_req(fnve_pkg::REQ_TICK, 3'd0, 32'hFFFF_FFFF));
        issue(make_req(fnve_pkg::REQ_RX, 3'd3, 32'd500, 8'h11, 8'hEE, fnve_pkg::VALUE_PKT_LEN));
        issue(make_req(fnve_pkg::REQ_SET_ALL, 3'd0, 32'd500, 8'd0, 8'd0, 8'd0, 8'd40));
        issue(make_req(fnve_pkg::REQ_QUERY, 3'd3, 32'd500));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: write_regs(1'b1, 16'd0, 16'd0, 6'd63);
                1: write_regs(1'b1, 16'hFFFF, 16'hFFFF, 6'd0);
                default: write_regs($urandom_range(0, 7) != 0, 16'($urandom_range(0, 400)),
                                    16'($urandom_range(0, 400)), 6'($urandom_range(0, 63)));
            endcase
            clock_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;
            run_phase(idle_modes[p % 4], PHASE_ITEMS);
        end
        drain();

        if (faces.mismatches == 0) begin
            $display("face_neighbor_value_exchange_top regression: pass");
        end else begin
            $display("face_neighbor_value_exchange_top regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("face_neighbor_value_exchange_top regression: fail");
        $finish;
    end

endmodule
